[sv/gbn_pkg.sv]
// Shared types and constants for the go-back-N link engine.
`default_nettype none
package gbn_pkg;

  // Fixed field widths on the channels
  localparam int OP_BITS      = 2;
  localparam int SEQ_BITS     = 3;
  localparam int KIND_BITS    = 2;
  localparam int PAYLOAD_BITS = 32;

  // Default window size (sequence numbers run modulo WINDOW+1)
  localparam int WINDOW_DEF = 7;

  typedef enum logic [OP_BITS-1:0] {
    OP_SEND    = 2'd0,
    OP_ARRIVE  = 2'd1,
    OP_CKERR   = 2'd2,
    OP_TIMEOUT = 2'd3
  } opcode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TX      = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_MATCH,
    ST_DELIVER,
    ST_RELEASE,
    ST_READ,
    ST_RESEND
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage
`default_nettype wire

[sv/gbn_cmd_if.sv]
// Command channel: one item per send, arrival, checksum error or timeout.
`default_nettype none
interface gbn_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [gbn_pkg::OP_BITS-1:0]      opcode;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] in_payload;
  logic [gbn_pkg::SEQ_BITS-1:0]     rx_seq;
  logic [gbn_pkg::SEQ_BITS-1:0]     rx_ack;

  modport source (output valid, opcode, in_payload, rx_seq, rx_ack, input ready);
  modport sink   (input valid, opcode, in_payload, rx_seq, rx_ack, output ready);
endinterface
`default_nettype wire

[sv/gbn_res_if.sv]
// Result channel: frames to transmit, deliveries, timer stops and refusals.
`default_nettype none
interface gbn_res_if;
  logic                             valid;
  logic                             ready;
  logic [gbn_pkg::KIND_BITS-1:0]    kind;
  logic [gbn_pkg::SEQ_BITS-1:0]     tx_seq;
  logic [gbn_pkg::SEQ_BITS-1:0]     tx_ack;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] out_payload;
  logic                             window_open;
  logic                             last_of_run;

  modport source (output valid, kind, tx_seq, tx_ack, out_payload, window_open,
                  last_of_run, input ready);
  modport sink   (input valid, kind, tx_seq, tx_ack, out_payload, window_open,
                  last_of_run, output ready);
endinterface
`default_nettype wire

[sv/gbn_seq_alu.sv]
// Shared modulo (WINDOW+1) add/subtract unit for sequence numbers.
`default_nettype none
module gbn_seq_alu #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  wire logic [$clog2(WINDOW+1)-1:0] a,
  input  wire logic [$clog2(WINDOW+1)-1:0] b,
  input  wire gbn_pkg::alu_op_t            op,
  output logic      [$clog2(WINDOW+1)-1:0] y
);
  localparam int SEQ_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SEQ_W + 1;
  localparam logic [SUM_W-1:0] MODULUS = SUM_W'(WINDOW + 1);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] diff;

  // One add or subtract, then a single wrap correction
  always_comb begin
    sum  = {1'b0, a} + {1'b0, b};
    diff = {1'b0, a} - {1'b0, b};
    case (op)
      gbn_pkg::ALU_ADD: y = (sum >= MODULUS) ? SEQ_W'(sum - MODULUS) : SEQ_W'(sum);
      gbn_pkg::ALU_SUB: y = diff[SEQ_W] ? SEQ_W'(diff + MODULUS) : SEQ_W'(diff);
      default:          y = SEQ_W'(sum);
    endcase
  end
endmodule
`default_nettype wire

[sv/go_back_n_link_engine.sv]
// Go-back-N link engine: window bookkeeping, frame store and result sequencer.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+----------------------------------------------------
//  cmd     | in  | valid/ready | opcode, in_payload, rx_seq, rx_ack
//  res     | out | valid/ready | kind, tx_seq, tx_ack, out_payload, window_open,
//          |     |             | last_of_run
//
// One item at a time. A send emits its frame or a refusal from the plan step; a
// checksum error is dropped there. An arrival plans, matches and delivers when
// the frame is in order, then stops one timer per released frame. A timeout
// plans, reads and resends each outstanding frame, or goes idle with none.
// The single sequence-number adder and one frame-store read port pace each step.
// rst is synchronous and clears all window state. A stalled result channel
// holds the sequencer in place until the output register frees up.
`default_nettype none
module go_back_n_link_engine #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input wire logic clk,
  input wire logic rst,
  gbn_cmd_if.sink  cmd,
  gbn_res_if.source res
);
  localparam int SEQ_W   = $clog2(WINDOW + 1);
  localparam int SEQ_B   = gbn_pkg::SEQ_BITS;
  localparam int PAY_W   = gbn_pkg::PAYLOAD_BITS;
  localparam int DEPTH   = WINDOW + 1;

  // Circular window test: b lies in [a, c)
  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                ((b < c) && (c < a));
  endfunction

  gbn_pkg::state_t  state, state_next;

  // Window state
  logic [SEQ_W-1:0] next_to_send, next_to_send_next;
  logic [SEQ_W-1:0] oldest_unacked, oldest_unacked_next;
  logic [SEQ_W-1:0] expected_inbound, expected_inbound_next;
  logic [SEQ_W-1:0] buffered_count, buffered_count_next;
  logic [SEQ_W-1:0] piggy_ack, piggy_ack_next;

  // Per-item working registers
  gbn_pkg::opcode_t op_q;
  logic [PAY_W-1:0] pay_q;
  logic [SEQ_B-1:0] rseq_q;
  logic [SEQ_B-1:0] rack_q;
  logic [SEQ_W-1:0] remain, remain_next;
  logic [SEQ_W-1:0] iter, iter_next;
  logic             win_q, win_q_next;

  // Frame store
  logic [PAY_W-1:0] store [DEPTH];
  logic [PAY_W-1:0] rd_data;
  logic             wr_en;
  logic             rd_en;
  logic [SEQ_W-1:0] rd_addr;

  // Output register
  logic             out_valid;
  gbn_pkg::kind_t   out_kind;
  logic [SEQ_B-1:0] out_seq;
  logic [SEQ_B-1:0] out_ack;
  logic [PAY_W-1:0] out_pay;
  logic             out_win;
  logic             out_last;

  // Result being emitted this cycle
  logic             emit;
  gbn_pkg::kind_t   e_kind;
  logic [SEQ_B-1:0] e_seq;
  logic [PAY_W-1:0] e_pay;
  logic             e_win;
  logic             e_last;
  logic             slot_free;

  // Shared sequence unit
  logic [SEQ_W-1:0] alu_a, alu_b, alu_y;
  gbn_pkg::alu_op_t alu_op;

  // Arrival decode
  logic [SEQ_W-1:0] rack_t;
  logic             rack_ok;
  logic             hit;
  logic [SEQ_W-1:0] rel;

  gbn_seq_alu #(.WINDOW(WINDOW)) u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  assign cmd.ready = (state == gbn_pkg::ST_IDLE);
  assign slot_free = !out_valid || res.ready;

  assign rack_t  = rack_q[SEQ_W-1:0];
  assign rack_ok = rack_q <= SEQ_B'(WINDOW);
  assign hit     = rack_ok && in_window(oldest_unacked, rack_t, next_to_send);
  // alu_y holds (rack - oldest) mod (WINDOW+1) in the plan step of an arrival
  assign rel     = hit ? alu_y + SEQ_W'(1) : '0;

  // Sequencer: next state, datapath control and result selection
  always_comb begin
    state_next            = state;
    next_to_send_next     = next_to_send;
    oldest_unacked_next   = oldest_unacked;
    expected_inbound_next = expected_inbound;
    buffered_count_next   = buffered_count;
    piggy_ack_next        = piggy_ack;
    remain_next           = remain;
    iter_next             = iter;
    win_q_next            = win_q;
    alu_a                 = next_to_send;
    alu_b                 = SEQ_W'(1);
    alu_op                = gbn_pkg::ALU_ADD;
    wr_en                 = 1'b0;
    rd_en                 = 1'b0;
    rd_addr               = iter;
    emit                  = 1'b0;
    e_kind                = gbn_pkg::KIND_TX;
    e_seq                 = '0;
    e_pay                 = '0;
    e_win                 = win_q;
    e_last                = 1'b0;

    case (state)
      gbn_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = gbn_pkg::ST_PLAN;
        end
      end

      gbn_pkg::ST_PLAN: begin
        case (op_q)
          gbn_pkg::OP_SEND: begin
            // Store and transmit, or refuse on a full window
            if (slot_free) begin
              emit       = 1'b1;
              e_last     = 1'b1;
              e_seq      = SEQ_B'(next_to_send);
              state_next = gbn_pkg::ST_IDLE;
              if (buffered_count < SEQ_W'(WINDOW)) begin
                wr_en               = 1'b1;
                e_kind              = gbn_pkg::KIND_TX;
                e_pay               = pay_q;
                e_win               = ({1'b0, buffered_count} + (SEQ_W+1)'(1)) <
                                      (SEQ_W+1)'(WINDOW);
                next_to_send_next   = alu_y;
                buffered_count_next = buffered_count + SEQ_W'(1);
              end else begin
                e_kind = gbn_pkg::KIND_REFUSED;
                e_win  = 1'b0;
              end
            end
          end
          gbn_pkg::OP_ARRIVE: begin
            // Work out how many timers the ack releases before emitting anything
            alu_a       = rack_t;
            alu_b       = oldest_unacked;
            alu_op      = gbn_pkg::ALU_SUB;
            remain_next = rel;
            win_q_next  = (buffered_count - rel) < SEQ_W'(WINDOW);
            if (rseq_q == SEQ_B'(expected_inbound)) begin
              state_next = gbn_pkg::ST_MATCH;
            end else if (rel != '0) begin
              state_next = gbn_pkg::ST_RELEASE;
            end else begin
              state_next = gbn_pkg::ST_IDLE;
            end
          end
          gbn_pkg::OP_TIMEOUT: begin
            iter_next   = oldest_unacked;
            remain_next = buffered_count;
            win_q_next  = buffered_count < SEQ_W'(WINDOW);
            state_next  = (buffered_count == '0) ? gbn_pkg::ST_IDLE : gbn_pkg::ST_READ;
          end
          default: begin
            state_next = gbn_pkg::ST_IDLE;
          end
        endcase
      end

      gbn_pkg::ST_MATCH: begin
        // In-order frame: advance expected; the ack trails it by one
        alu_a                 = expected_inbound;
        expected_inbound_next = alu_y;
        piggy_ack_next        = expected_inbound;
        state_next            = gbn_pkg::ST_DELIVER;
      end

      gbn_pkg::ST_DELIVER: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_kind     = gbn_pkg::KIND_DELIVER;
          e_seq      = rseq_q;
          e_pay      = pay_q;
          e_last     = (remain == '0);
          state_next = (remain == '0) ? gbn_pkg::ST_IDLE : gbn_pkg::ST_RELEASE;
        end
      end

      gbn_pkg::ST_RELEASE: begin
        // Stop one timer per cycle while the output slot is free, oldest first
        alu_a = oldest_unacked;
        if (slot_free) begin
          emit                = 1'b1;
          e_kind              = gbn_pkg::KIND_STOP;
          e_seq               = SEQ_B'(oldest_unacked);
          e_last              = (remain == SEQ_W'(1));
          oldest_unacked_next = alu_y;
          buffered_count_next = buffered_count - SEQ_W'(1);
          remain_next         = remain - SEQ_W'(1);
          if (remain == SEQ_W'(1)) begin
            state_next = gbn_pkg::ST_IDLE;
          end
        end
      end

      gbn_pkg::ST_READ: begin
        rd_en      = 1'b1;
        rd_addr    = iter;
        state_next = gbn_pkg::ST_RESEND;
      end

      gbn_pkg::ST_RESEND: begin
        // Resend one frame per cycle while the output slot is free, fetching the following one
        alu_a = iter;
        if (slot_free) begin
          emit        = 1'b1;
          e_kind      = gbn_pkg::KIND_TX;
          e_seq       = SEQ_B'(iter);
          e_pay       = rd_data;
          e_last      = (remain == SEQ_W'(1));
          rd_en       = 1'b1;
          rd_addr     = alu_y;
          iter_next   = alu_y;
          remain_next = remain - SEQ_W'(1);
          if (remain == SEQ_W'(1)) begin
            next_to_send_next = alu_y;
            state_next        = gbn_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= gbn_pkg::ST_IDLE;
      next_to_send     <= '0;
      oldest_unacked   <= '0;
      expected_inbound <= '0;
      buffered_count   <= '0;
      piggy_ack        <= SEQ_W'(WINDOW);
      remain           <= '0;
      iter             <= '0;
      win_q            <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      next_to_send     <= next_to_send_next;
      oldest_unacked   <= oldest_unacked_next;
      expected_inbound <= expected_inbound_next;
      buffered_count   <= buffered_count_next;
      piggy_ack        <= piggy_ack_next;
      remain           <= remain_next;
      iter             <= iter_next;
      win_q            <= win_q_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q   <= gbn_pkg::opcode_t'(cmd.opcode);
      pay_q  <= cmd.in_payload;
      rseq_q <= cmd.rx_seq;
      rack_q <= cmd.rx_ack;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= e_kind;
      out_seq  <= e_seq;
      out_ack  <= SEQ_B'(piggy_ack);
      out_pay  <= e_pay;
      out_win  <= e_win;
      out_last <= e_last;
    end
  end

  // Frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[next_to_send] <= pay_q;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  assign res.valid       = out_valid;
  assign res.kind        = out_kind;
  assign res.tx_seq      = out_seq;
  assign res.tx_ack      = out_ack;
  assign res.out_payload = out_pay;
  assign res.window_open = out_win;
  assign res.last_of_run = out_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    buffered_count <= SEQ_W'(WINDOW))
    else $error("buffered count above window");

  a_accept_plans: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (state == gbn_pkg::ST_PLAN))
    else $error("accepted item not planned");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == gbn_pkg::ST_IDLE) |-> (remain == '0))
    else $error("idle with work left");

  a_release_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == gbn_pkg::ST_RELEASE || state == gbn_pkg::ST_RESEND) |->
      (buffered_count != '0))
    else $error("timer work on empty window");
endmodule
`default_nettype wire
